### design/cmhd_pkg.sv
// Shared types, constants and channel tables for the colour match detector.
package cmhd_pkg;

    // Field widths
    localparam int PULSE_W     = 16;
    localparam int COMP_W      = 8;
    localparam int GAP_W       = 18;
    localparam int DIST_W      = 18;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 18;

    // Internal widths: mapped channel values, spans and divider operands
    localparam int CH_W        = 21;
    localparam int SPAN_W      = 19;
    localparam int DIVIDEND_W  = 28;
    localparam int DIVISOR_W   = 19;

    // Arithmetic constants
    localparam int FULL_SCALE  = 255;
    localparam int NARROW_SPAN = 100;

    // Reset values of the gap registers
    localparam logic [GAP_W-1:0] GAP_CENTER_RESET     = 18'd100000;
    localparam logic [GAP_W-1:0] GAP_HYSTERESIS_RESET = 18'd25000;

    // Channel codes
    typedef logic [1:0] chan_t;
    localparam chan_t CH_RED   = 2'd0;
    localparam chan_t CH_GREEN = 2'd1;
    localparam chan_t CH_BLUE  = 2'd2;

    // Configuration register indexes
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    localparam cfg_index_t REG_REFERENCE_RED   = 3'd0;
    localparam cfg_index_t REG_REFERENCE_GREEN = 3'd1;
    localparam cfg_index_t REG_REFERENCE_BLUE  = 3'd2;
    localparam cfg_index_t REG_GAP_CENTER      = 3'd3;
    localparam cfg_index_t REG_GAP_HYSTERESIS  = 3'd4;

    // Input request: three raw pulse widths
    typedef struct packed {
        logic [PULSE_W-1:0] pulse_red;
        logic [PULSE_W-1:0] pulse_green;
        logic [PULSE_W-1:0] pulse_blue;
    } item_t;

    // Result request
    typedef struct packed {
        logic              detected;
        logic [COMP_W-1:0] average_red;
        logic [COMP_W-1:0] average_green;
        logic [COMP_W-1:0] average_blue;
        logic [DIST_W-1:0] color_distance;
    } result_t;

    // Divider command and response
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MAP,
        S_MAP_WAIT,
        S_RANGE,
        S_WIDEN_MX,
        S_WIDEN_MN,
        S_SPAN,
        S_NORM,
        S_NORM_WAIT,
        S_AVG,
        S_AVG_WAIT,
        S_SQUARE,
        S_DECIDE,
        S_EMIT
    } state_t;

    // Low end of the pulse range of each channel
    function automatic logic [PULSE_W-1:0] map_low(input chan_t ch);
        logic [PULSE_W-1:0] low;
        unique case (ch)
            CH_RED:   low = 16'd25;
            CH_GREEN: low = 16'd30;
            CH_BLUE:  low = 16'd25;
            default:  low = 16'd25;
        endcase
        return low;
    endfunction

    // Width of the pulse range of each channel (high minus low)
    function automatic logic [DIVISOR_W-1:0] map_range(input chan_t ch);
        logic [DIVISOR_W-1:0] range;
        unique case (ch)
            CH_RED:   range = 19'd47;
            CH_GREEN: range = 19'd60;
            CH_BLUE:  range = 19'd45;
            default:  range = 19'd47;
        endcase
        return range;
    endfunction

endpackage

### design/cmhd_div.sv
// Iterative unsigned restoring divider, two quotient bits per cycle.
module cmhd_div (
    input  logic               clk,
    input  logic               rst_n,
    input  cmhd_pkg::div_req_t req,
    output cmhd_pkg::div_rsp_t rsp
);

    localparam int STEPS   = cmhd_pkg::DIVIDEND_W / 2;
    localparam int COUNT_W = $clog2(STEPS);
    localparam int DW      = cmhd_pkg::DIVIDEND_W;
    localparam int VW      = cmhd_pkg::DIVISOR_W;

    logic               busy_reg,    busy_next;
    logic               done_reg,    done_next;
    logic [COUNT_W-1:0] count_reg,   count_next;
    logic [DW-1:0]      quo_reg,     quo_next;
    logic [VW-1:0]      rem_reg,     rem_next;
    logic [VW-1:0]      divisor_reg, divisor_next;

    logic [DW-1:0]      quo_step;
    logic [VW-1:0]      rem_step;

    // Retire two quotient bits: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        logic [VW:0] trial;
        quo_step = quo_reg;
        rem_step = rem_reg;
        for (int k = 0; k < 2; k++)
        begin
            trial    = {rem_step, quo_step[DW-1]};
            quo_step = {quo_step[DW-2:0], 1'b0};
            if (trial >= {1'b0, divisor_reg})
            begin
                trial       = trial - {1'b0, divisor_reg};
                quo_step[0] = 1'b1;
            end
            rem_step = trial[VW-1:0];
        end
    end

    // Load on start, iterate while busy, flag the last step
    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            count_next   = '0;
            quo_next     = req.dividend;
            rem_next     = '0;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next   = quo_step;
            rem_next   = rem_step;
            count_next = count_reg + 1'b1;
            if (count_reg == COUNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### design/color_match_hysteresis_detector.sv
// Top level of the colour match detector: sequencer, datapath and registers.
//
// Each accepted request runs nine divisions (three channel mappings, three
// normalizations, three averages) one after another on a single shared divider
// that retires two quotient bits per cycle, plus the steps of range finding,
// span widening, squaring, the threshold decision and loading the output
// register. When the three mapped channels are equal the normalizations are
// skipped. A new request is taken the cycle after the result is loaded into the
// output register, even while that result still waits to be taken, so a new
// request is not taken before the block is through with the last one.
// Configuration writes are accepted on every cycle.
module color_match_hysteresis_detector #(
    parameter int WINDOW_LENGTH = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  cmhd_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output cmhd_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cmhd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cmhd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int HIST_D = (WINDOW_LENGTH > 1) ? WINDOW_LENGTH - 1 : 1;
    localparam int SUM_W  = $clog2(WINDOW_LENGTH * 255 + 1);
    localparam int CH_W   = cmhd_pkg::CH_W;
    localparam int SPAN_W = cmhd_pkg::SPAN_W;
    localparam int CW     = cmhd_pkg::COMP_W;
    localparam int GW     = cmhd_pkg::GAP_W;
    localparam int DSW    = cmhd_pkg::DIST_W;
    localparam int PW     = cmhd_pkg::PULSE_W;

    // Sequencer and control
    cmhd_pkg::state_t  state_reg, state_next;
    cmhd_pkg::chan_t   chan_reg,  chan_next;

    // Item data
    cmhd_pkg::item_t          pulse_reg,  pulse_next;
    logic signed [CH_W-1:0]   ch_reg   [3];
    logic signed [CH_W-1:0]   ch_next  [3];
    logic signed [CH_W-1:0]   mx_reg,     mx_next;
    logic signed [CH_W-1:0]   mn_reg,     mn_next;
    logic                     narrow_reg, narrow_next;
    logic [SPAN_W-1:0]        span_reg,   span_next;
    logic [CW-1:0]            norm_reg [3];
    logic [CW-1:0]            norm_next[3];
    logic [CW-1:0]            avg_reg  [3];
    logic [CW-1:0]            avg_next [3];
    logic [DSW-1:0]           dist_reg,   dist_next;

    // Persistent state
    logic [CW-1:0]            hist_reg [3][HIST_D];
    logic [CW-1:0]            hist_next[3][HIST_D];
    logic                     flag_reg,   flag_next;

    // Configuration
    logic [CW-1:0]            ref_red_reg,    ref_red_next;
    logic [CW-1:0]            ref_green_reg,  ref_green_next;
    logic [CW-1:0]            ref_blue_reg,   ref_blue_next;
    logic [GW-1:0]            gap_center_reg, gap_center_next;
    logic [GW-1:0]            gap_hyst_reg,   gap_hyst_next;

    // Output register
    cmhd_pkg::result_t        result_reg,       result_next;
    logic                     result_valid_reg, result_valid_next;

    // Divider link
    cmhd_pkg::div_req_t       div_req;
    cmhd_pkg::div_rsp_t       div_rsp;

    // Datapath wires
    logic                     last_chan;
    logic                     emit_fire;
    logic [PW-1:0]            pulse_sel;
    logic [PW-1:0]            low_sel;
    logic                     pulse_below;
    logic [PW-1:0]            abs_diff;
    logic [PW+CW-1:0]         map_mag;
    logic signed [CH_W-1:0]   map_value;
    logic signed [CH_W-1:0]   ch_sel;
    logic signed [CH_W-1:0]   range_mx;
    logic signed [CH_W-1:0]   range_mn;
    logic signed [CH_W-1:0]   range_diff;
    logic signed [CH_W-1:0]   widen_diff;
    logic signed [CH_W-1:0]   offset;
    logic [SPAN_W+CW-1:0]     norm_scaled;
    logic [CW-1:0]            norm_sel;
    logic [CW-1:0]            hist_sel [HIST_D];
    logic [SUM_W-1:0]         avg_sum;
    logic [CW-1:0]            ref_sel;
    logic [CW-1:0]            avg_sel;
    logic [CW-1:0]            abs_comp;
    logic [2*CW-1:0]          square;
    logic [GW:0]              upper_bound;
    logic [GW:0]              shifted_dist;
    logic                     chan_step;

    cmhd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign last_chan = (chan_reg == cmhd_pkg::CH_BLUE);
    assign emit_fire = (state_reg == cmhd_pkg::S_EMIT) && (!result_valid_reg || !result_stall);

    // Select the working channel's operands
    always_comb
    begin
        unique case (chan_reg)
            cmhd_pkg::CH_RED:
            begin
                pulse_sel = pulse_reg.pulse_red;
                ch_sel    = ch_reg[0];
                norm_sel  = norm_reg[0];
                hist_sel  = hist_reg[0];
                ref_sel   = ref_red_reg;
                avg_sel   = avg_reg[0];
            end
            cmhd_pkg::CH_GREEN:
            begin
                pulse_sel = pulse_reg.pulse_green;
                ch_sel    = ch_reg[1];
                norm_sel  = norm_reg[1];
                hist_sel  = hist_reg[1];
                ref_sel   = ref_green_reg;
                avg_sel   = avg_reg[1];
            end
            default:
            begin
                pulse_sel = pulse_reg.pulse_blue;
                ch_sel    = ch_reg[2];
                norm_sel  = norm_reg[2];
                hist_sel  = hist_reg[2];
                ref_sel   = ref_blue_reg;
                avg_sel   = avg_reg[2];
            end
        endcase
    end

    // Linear map: magnitude of (p - low) * 255 goes to the divider, sign applied after
    always_comb
    begin
        low_sel     = cmhd_pkg::map_low(chan_reg);
        pulse_below = (pulse_sel < low_sel);
        abs_diff    = pulse_below ? (low_sel - pulse_sel) : (pulse_sel - low_sel);
        map_mag     = {abs_diff, {CW{1'b0}}} - (PW+CW)'(abs_diff);
        if (pulse_below)
            map_value = CH_W'(cmhd_pkg::FULL_SCALE)
                      + signed'({2'b00, div_rsp.quotient[SPAN_W-1:0]});
        else
            map_value = CH_W'(cmhd_pkg::FULL_SCALE)
                      - signed'({2'b00, div_rsp.quotient[SPAN_W-1:0]});
    end

    // Minimum, maximum and widening of a narrow span
    always_comb
    begin
        range_mx = ch_reg[0];
        range_mn = ch_reg[0];
        for (int i = 1; i < 3; i++)
        begin
            if (ch_reg[i] > range_mx)
                range_mx = ch_reg[i];
            if (ch_reg[i] < range_mn)
                range_mn = ch_reg[i];
        end
        range_diff = range_mx - range_mn;
        widen_diff = mx_reg - mn_reg;
    end

    // Normalization dividend (v - min) * 255 and the window sum
    always_comb
    begin
        offset      = ch_sel - mn_reg;
        norm_scaled = {offset[SPAN_W-1:0], {CW{1'b0}}} - (SPAN_W+CW)'(offset[SPAN_W-1:0]);
        avg_sum     = SUM_W'(norm_sel);
        for (int i = 0; i < HIST_D; i++)
        begin
            if (i < WINDOW_LENGTH - 1)
                avg_sum = avg_sum + SUM_W'(hist_sel[i]);
        end
    end

    // Squared difference to the reference and the hysteresis bounds
    always_comb
    begin
        abs_comp     = (ref_sel > avg_sel) ? (ref_sel - avg_sel) : (avg_sel - ref_sel);
        square       = abs_comp * abs_comp;
        upper_bound  = {1'b0, gap_center_reg} + {1'b0, gap_hyst_reg};
        shifted_dist = (GW+1)'(dist_reg) + {1'b0, gap_hyst_reg};
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cmhd_pkg::S_IDLE:
                if (item_valid)
                    state_next = cmhd_pkg::S_MAP;
            cmhd_pkg::S_MAP:
                state_next = cmhd_pkg::S_MAP_WAIT;
            cmhd_pkg::S_MAP_WAIT:
                if (div_rsp.done)
                    state_next = last_chan ? cmhd_pkg::S_RANGE : cmhd_pkg::S_MAP;
            cmhd_pkg::S_RANGE:
                state_next = cmhd_pkg::S_WIDEN_MX;
            cmhd_pkg::S_WIDEN_MX:
                state_next = cmhd_pkg::S_WIDEN_MN;
            cmhd_pkg::S_WIDEN_MN:
                state_next = cmhd_pkg::S_SPAN;
            cmhd_pkg::S_SPAN:
                state_next = cmhd_pkg::S_NORM;
            cmhd_pkg::S_NORM:
                if (span_reg != '0)
                    state_next = cmhd_pkg::S_NORM_WAIT;
                else
                    state_next = last_chan ? cmhd_pkg::S_AVG : cmhd_pkg::S_NORM;
            cmhd_pkg::S_NORM_WAIT:
                if (div_rsp.done)
                    state_next = last_chan ? cmhd_pkg::S_AVG : cmhd_pkg::S_NORM;
            cmhd_pkg::S_AVG:
                state_next = cmhd_pkg::S_AVG_WAIT;
            cmhd_pkg::S_AVG_WAIT:
                if (div_rsp.done)
                    state_next = last_chan ? cmhd_pkg::S_SQUARE : cmhd_pkg::S_AVG;
            cmhd_pkg::S_SQUARE:
                if (last_chan)
                    state_next = cmhd_pkg::S_DECIDE;
            cmhd_pkg::S_DECIDE:
                state_next = cmhd_pkg::S_EMIT;
            cmhd_pkg::S_EMIT:
                if (emit_fire)
                    state_next = cmhd_pkg::S_IDLE;
            default:
                state_next = cmhd_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and divider commands
    always_comb
    begin
        item_stall       = (state_reg != cmhd_pkg::S_IDLE);
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (state_reg)
            cmhd_pkg::S_MAP:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = cmhd_pkg::DIVIDEND_W'(map_mag);
                div_req.divisor  = cmhd_pkg::map_range(chan_reg);
            end
            cmhd_pkg::S_NORM:
            begin
                div_req.start    = (span_reg != '0);
                div_req.dividend = cmhd_pkg::DIVIDEND_W'(norm_scaled);
                div_req.divisor  = cmhd_pkg::DIVISOR_W'(span_reg);
            end
            cmhd_pkg::S_AVG:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = cmhd_pkg::DIVIDEND_W'(avg_sum);
                div_req.divisor  = cmhd_pkg::DIVISOR_W'(WINDOW_LENGTH);
            end
            default:
            begin
                div_req.start    = 1'b0;
            end
        endcase
    end

    // Datapath register updates
    always_comb
    begin
        pulse_next        = pulse_reg;
        ch_next           = ch_reg;
        mx_next           = mx_reg;
        mn_next           = mn_reg;
        narrow_next       = narrow_reg;
        span_next         = span_reg;
        norm_next         = norm_reg;
        avg_next          = avg_reg;
        dist_next         = dist_reg;
        hist_next         = hist_reg;
        flag_next         = flag_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        chan_step         = 1'b0;

        unique case (state_reg)
            cmhd_pkg::S_IDLE:
            begin
                pulse_next = item;
                dist_next  = '0;
            end
            cmhd_pkg::S_MAP_WAIT:
                if (div_rsp.done)
                begin
                    ch_next[chan_reg] = map_value;
                    chan_step         = 1'b1;
                end
            cmhd_pkg::S_RANGE:
            begin
                mx_next     = range_mx;
                mn_next     = range_mn;
                narrow_next = (range_diff < CH_W'(cmhd_pkg::NARROW_SPAN));
            end
            cmhd_pkg::S_WIDEN_MX:
                if (narrow_reg)
                    mx_next = mx_reg + (widen_diff >>> 1);
            cmhd_pkg::S_WIDEN_MN:
                if (narrow_reg)
                    mn_next = mn_reg - (widen_diff >>> 1);
            cmhd_pkg::S_SPAN:
                span_next = widen_diff[SPAN_W-1:0];
            cmhd_pkg::S_NORM:
                if (span_reg == '0)
                begin
                    norm_next[chan_reg] = '0;
                    chan_step           = 1'b1;
                end
            cmhd_pkg::S_NORM_WAIT:
                if (div_rsp.done)
                begin
                    norm_next[chan_reg] = div_rsp.quotient[CW-1:0];
                    chan_step           = 1'b1;
                end
            cmhd_pkg::S_AVG:
            begin
                // Drop the oldest sample, push the new one in front
                if (WINDOW_LENGTH > 1)
                begin
                    for (int i = HIST_D - 1; i > 0; i--)
                        hist_next[chan_reg][i] = hist_reg[chan_reg][i-1];
                    hist_next[chan_reg][0] = norm_sel;
                end
            end
            cmhd_pkg::S_AVG_WAIT:
                if (div_rsp.done)
                begin
                    avg_next[chan_reg] = div_rsp.quotient[CW-1:0];
                    chan_step          = 1'b1;
                end
            cmhd_pkg::S_SQUARE:
            begin
                dist_next = dist_reg + DSW'(square);
                chan_step = 1'b1;
            end
            cmhd_pkg::S_DECIDE:
            begin
                // Set below the lower bound, clear above the upper bound
                if (!flag_reg)
                    flag_next = (shifted_dist < {1'b0, gap_center_reg});
                else
                    flag_next = !((GW+1)'(dist_reg) > upper_bound);
            end
            default:
            begin
                chan_step = 1'b0;
            end
        endcase

        // Load the output register or release it once taken
        if (emit_fire)
        begin
            result_next.detected       = flag_reg;
            result_next.average_red    = avg_reg[0];
            result_next.average_green  = avg_reg[1];
            result_next.average_blue   = avg_reg[2];
            result_next.color_distance = dist_reg;
            result_valid_next          = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        // Advance the channel counter
        if (chan_step)
            chan_next = last_chan ? cmhd_pkg::CH_RED : chan_reg + 1'b1;
        else
            chan_next = chan_reg;
    end

    // Configuration writes
    always_comb
    begin
        ref_red_next    = ref_red_reg;
        ref_green_next  = ref_green_reg;
        ref_blue_next   = ref_blue_reg;
        gap_center_next = gap_center_reg;
        gap_hyst_next   = gap_hyst_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cmhd_pkg::REG_REFERENCE_RED:   ref_red_next    = cfg_data[CW-1:0];
                cmhd_pkg::REG_REFERENCE_GREEN: ref_green_next  = cfg_data[CW-1:0];
                cmhd_pkg::REG_REFERENCE_BLUE:  ref_blue_next   = cfg_data[CW-1:0];
                cmhd_pkg::REG_GAP_CENTER:      gap_center_next = cfg_data[GW-1:0];
                cmhd_pkg::REG_GAP_HYSTERESIS:  gap_hyst_next   = cfg_data[GW-1:0];
                default:                       ref_red_next    = ref_red_reg;
            endcase
        end
    end

    // Control, history and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= cmhd_pkg::S_IDLE;
            chan_reg         <= cmhd_pkg::CH_RED;
            result_valid_reg <= 1'b0;
            flag_reg         <= 1'b0;
            ref_red_reg      <= '0;
            ref_green_reg    <= '0;
            ref_blue_reg     <= '0;
            gap_center_reg   <= cmhd_pkg::GAP_CENTER_RESET;
            gap_hyst_reg     <= cmhd_pkg::GAP_HYSTERESIS_RESET;
            for (int c = 0; c < 3; c++)
                for (int i = 0; i < HIST_D; i++)
                    hist_reg[c][i] <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            chan_reg         <= chan_next;
            result_valid_reg <= result_valid_next;
            flag_reg         <= flag_next;
            ref_red_reg      <= ref_red_next;
            ref_green_reg    <= ref_green_next;
            ref_blue_reg     <= ref_blue_next;
            gap_center_reg   <= gap_center_next;
            gap_hyst_reg     <= gap_hyst_next;
            hist_reg         <= hist_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pulse_reg  <= pulse_next;
        ch_reg     <= ch_next;
        mx_reg     <= mx_next;
        mn_reg     <= mn_next;
        narrow_reg <= narrow_next;
        span_reg   <= span_next;
        norm_reg   <= norm_next;
        avg_reg    <= avg_next;
        dist_reg   <= dist_next;
        result_reg <= result_next;
    end

    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A result appears only out of the emit step
    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == cmhd_pkg::S_EMIT))
        else $error("result offered outside the emit step");

    // The divider only answers while the sequencer waits for it
    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == cmhd_pkg::S_MAP_WAIT
                       || state_reg == cmhd_pkg::S_NORM_WAIT
                       || state_reg == cmhd_pkg::S_AVG_WAIT))
        else $error("divider finished with nobody waiting");

    // The widened range never inverts
    a_range_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cmhd_pkg::S_NORM) |-> (mx_reg >= mn_reg))
        else $error("normalization range inverted");

    // The detection flag moves only in the decision step
    a_flag_at_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (flag_reg != $past(flag_reg)) |-> $past(state_reg == cmhd_pkg::S_DECIDE))
        else $error("detection flag changed outside the decision step");

endmodule

### dv/color_match_hysteresis_detector_tb.sv
// Self-checking testbench for the colour match hysteresis detector.
`timescale 1ns / 100ps

module color_match_hysteresis_detector_tb;

    localparam int          WINDOW_LENGTH = 3;
    localparam int          CFG_W         = cmhd_pkg::CFG_DATA_W;
    localparam int          PW            = cmhd_pkg::PULSE_W;
    localparam int unsigned RED_LOW       = 25;
    localparam int unsigned RED_HIGH      = 72;
    localparam int unsigned GREEN_LOW     = 30;
    localparam int unsigned GREEN_HIGH    = 90;
    localparam int unsigned BLUE_LOW      = 25;
    localparam int unsigned BLUE_HIGH     = 70;
    localparam int unsigned PULSE_MAX     = 32'h0000_FFFF;
    localparam int unsigned PULSE_ALT_A   = 32'h0000_AAAA;
    localparam int unsigned PULSE_ALT_B   = 32'h0000_5555;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_ITEMS   = 135;
    localparam int unsigned LONG_HOLD     = 1500;
    localparam int unsigned SETTLE_CYCLES = 200;
    localparam int unsigned CYCLE_LIMIT   = 1200000;

    logic                                clk          = 1'b0;
    logic                                rst_n        = 1'b0;
    logic                                item_valid   = 1'b0;
    logic                                item_stall;
    cmhd_pkg::item_t                     item         = '0;
    logic                                result_valid;
    logic                                result_stall = 1'b0;
    cmhd_pkg::result_t                   result;
    logic                                cfg_valid    = 1'b0;
    logic                                cfg_ready;
    logic [cmhd_pkg::CFG_INDEX_W-1:0]    cfg_index    = '0;
    logic [CFG_W-1:0]                    cfg_data     = '0;

    bit          tx_idling     = 1'b1;
    bit          rx_idling     = 1'b1;
    bit          long_hold_req = 1'b0;
    int unsigned long_holds    = 0;
    int unsigned settings_used = 0;

    // Tracks colour readings, predicts averages, distance and the detect flag
    class color_match_tracker;
        logic [cmhd_pkg::COMP_W-1:0] target [3];
        logic [cmhd_pkg::GAP_W-1:0]  gap_mid;
        logic [cmhd_pkg::GAP_W-1:0]  gap_half;
        logic [cmhd_pkg::COMP_W-1:0] recent [3][2];
        bit                          flag;
        cmhd_pkg::result_t           awaited_results [$];
        int unsigned                 mismatches;
        int unsigned                 readings;
        int unsigned                 results_seen;
        int unsigned                 flag_changes;
        int unsigned                 reg_writes;

        function new();
            for (int i = 0; i < 3; i++)
            begin
                target[i]    = '0;
                recent[i][0] = '0;
                recent[i][1] = '0;
            end
            gap_mid      = cmhd_pkg::GAP_CENTER_RESET;
            gap_half     = cmhd_pkg::GAP_HYSTERESIS_RESET;
            flag         = 1'b0;
            mismatches   = 0;
            readings     = 0;
            results_seen = 0;
            flag_changes = 0;
            reg_writes   = 0;
        endfunction

        function void set_register(cmhd_pkg::cfg_index_t idx, logic [CFG_W-1:0] data);
            reg_writes++;
            case (idx)
                cmhd_pkg::REG_REFERENCE_RED:   target[0] = data[cmhd_pkg::COMP_W-1:0];
                cmhd_pkg::REG_REFERENCE_GREEN: target[1] = data[cmhd_pkg::COMP_W-1:0];
                cmhd_pkg::REG_REFERENCE_BLUE:  target[2] = data[cmhd_pkg::COMP_W-1:0];
                cmhd_pkg::REG_GAP_CENTER:      gap_mid   = data[cmhd_pkg::GAP_W-1:0];
                cmhd_pkg::REG_GAP_HYSTERESIS:  gap_half  = data[cmhd_pkg::GAP_W-1:0];
                default: ;
            endcase
        endfunction

        // Linear pulse-to-channel mapping, truncating toward zero, unclamped
        function longint map_pulse(longint p, longint lo, longint hi);
            return (p - lo) * (-255) / (hi - lo) + 255;
        endfunction

        function void absorb_reading(cmhd_pkg::item_t rd);
            longint                      chan [3];
            longint                      top_v;
            longint                      bot_v;
            longint                      spread;
            logic [cmhd_pkg::COMP_W-1:0] norm [3];
            logic [cmhd_pkg::COMP_W-1:0] avg [3];
            logic [cmhd_pkg::COMP_W-1:0] diff;
            int unsigned                 sum;
            int unsigned                 sq_total;
            longint                      lower;
            longint                      upper;
            bit                          old_flag;
            cmhd_pkg::result_t           want;

            readings++;
            chan[0] = map_pulse(longint'(rd.pulse_red), longint'(RED_LOW),
                                longint'(RED_HIGH));
            chan[1] = map_pulse(longint'(rd.pulse_green), longint'(GREEN_LOW),
                                longint'(GREEN_HIGH));
            chan[2] = map_pulse(longint'(rd.pulse_blue), longint'(BLUE_LOW),
                                longint'(BLUE_HIGH));

            // Find the span, widening a narrow one with the maximum moved first
            top_v = chan[0];
            bot_v = chan[0];
            for (int i = 1; i < 3; i++)
            begin
                if (chan[i] > top_v) top_v = chan[i];
                if (chan[i] < bot_v) bot_v = chan[i];
            end
            if (top_v - bot_v < longint'(cmhd_pkg::NARROW_SPAN))
            begin
                top_v = top_v + (top_v - bot_v) / 2;
                bot_v = bot_v - (top_v - bot_v) / 2;
            end
            spread = top_v - bot_v;

            // Normalize, average over the window and accumulate the distance
            sq_total = 0;
            for (int i = 0; i < 3; i++)
            begin
                norm[i] = (spread == 0) ? 8'd0
                        : 8'((chan[i] - bot_v) * longint'(cmhd_pkg::FULL_SCALE) / spread);
                sum = int'(norm[i]) + int'(recent[i][0]) + int'(recent[i][1]);
                recent[i][1] = recent[i][0];
                recent[i][0] = norm[i];
                avg[i] = 8'(sum / WINDOW_LENGTH);
                diff = (avg[i] > target[i]) ? avg[i] - target[i] : target[i] - avg[i];
                sq_total += int'(diff) * int'(diff);
            end

            // Hysteresis on signed bounds
            lower    = longint'(gap_mid) - longint'(gap_half);
            upper    = longint'(gap_mid) + longint'(gap_half);
            old_flag = flag;
            if (!flag && longint'(sq_total) < lower) flag = 1'b1;
            if (flag && longint'(sq_total) > upper) flag = 1'b0;
            if (flag != old_flag) flag_changes++;

            want.detected       = flag;
            want.average_red    = avg[0];
            want.average_green  = avg[1];
            want.average_blue   = avg[2];
            want.color_distance = sq_total[cmhd_pkg::DIST_W-1:0];
            awaited_results.push_back(want);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("%0t: mismatch: %s", $realtime, msg);
        endtask

        task check_field(string name, logic [31:0] got_v, logic [31:0] want_v);
            if (got_v !== want_v)
                report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                          results_seen, name, got_v, want_v));
        endtask

        task compare_result(cmhd_pkg::result_t got);
            cmhd_pkg::result_t want;
            results_seen++;
            if (awaited_results.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                          results_seen));
                return;
            end
            want = awaited_results.pop_front();
            check_field("detected", 32'(got.detected), 32'(want.detected));
            check_field("average_red", 32'(got.average_red), 32'(want.average_red));
            check_field("average_green", 32'(got.average_green), 32'(want.average_green));
            check_field("average_blue", 32'(got.average_blue), 32'(want.average_blue));
            check_field("color_distance", 32'(got.color_distance),
                        32'(want.color_distance));
        endtask
    endclass

    color_match_tracker tracker = new();

    color_match_hysteresis_detector #(
        .WINDOW_LENGTH(WINDOW_LENGTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Note accepted readings and check accepted results
    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            tracker.absorb_reading(item);
        if (rst_n && result_valid && !result_stall)
            tracker.compare_result(result);
    end

    // Result side stall: random bursts plus one long hold on request
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                hold_left--;
                if (hold_left == 0) result_stall <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                long_holds++;
                result_stall <= 1'b1;
                hold_left = LONG_HOLD;
            end
            else if (rx_idling && $urandom_range(0, 7) == 0)
            begin
                result_stall <= 1'b1;
                hold_left = $urandom_range(1, 12);
            end
        end
    end

    // Run limit
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic cmhd_pkg::item_t make_reading(int unsigned r, int unsigned g,
                                                     int unsigned b);
        cmhd_pkg::item_t rd;
        rd.pulse_red   = PW'(r);
        rd.pulse_green = PW'(g);
        rd.pulse_blue  = PW'(b);
        return rd;
    endfunction

    // Offer one reading, hold it until taken, then maybe idle a burst
    task automatic send_reading(cmhd_pkg::item_t rd);
        int unsigned gap;
        item       <= rd;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
        if (tx_idling && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_repeated(cmhd_pkg::item_t rd, int unsigned count);
        repeat (count) send_reading(rd);
    endtask

    // Drop valid and wait until every outstanding result has been taken
    task automatic wait_quiet();
        item_valid <= 1'b0;
        @(posedge clk);
        while (tracker.awaited_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cmhd_pkg::cfg_index_t idx, logic [CFG_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        tracker.set_register(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Register settings for each random phase, extremes first
    task automatic program_phase(int unsigned phase);
        settings_used++;
        case (phase)
            0:
            begin
                write_reg(cmhd_pkg::REG_REFERENCE_RED, '0);
                write_reg(cmhd_pkg::REG_REFERENCE_GREEN, '0);
                write_reg(cmhd_pkg::REG_REFERENCE_BLUE, '0);
                write_reg(cmhd_pkg::REG_GAP_CENTER, '0);
                write_reg(cmhd_pkg::REG_GAP_HYSTERESIS, '0);
            end
            1:
            begin
                write_reg(cmhd_pkg::REG_REFERENCE_RED, '1);
                write_reg(cmhd_pkg::REG_REFERENCE_GREEN, '1);
                write_reg(cmhd_pkg::REG_REFERENCE_BLUE, '1);
                write_reg(cmhd_pkg::REG_GAP_CENTER, '1);
                write_reg(cmhd_pkg::REG_GAP_HYSTERESIS, '1);
            end
            2:
            begin
                write_reg(cmhd_pkg::REG_GAP_HYSTERESIS, '0);
            end
            default:
            begin
                if ($urandom_range(0, 3) != 0)
                    write_reg(cmhd_pkg::REG_REFERENCE_RED, CFG_W'($urandom));
                if ($urandom_range(0, 3) != 0)
                    write_reg(cmhd_pkg::REG_REFERENCE_GREEN, CFG_W'($urandom));
                if ($urandom_range(0, 3) != 0)
                    write_reg(cmhd_pkg::REG_REFERENCE_BLUE, CFG_W'($urandom));
                if ($urandom_range(0, 3) != 0)
                    write_reg(cmhd_pkg::REG_GAP_CENTER, CFG_W'($urandom_range(5000, 120000)));
                if ($urandom_range(0, 3) != 0)
                    write_reg(cmhd_pkg::REG_GAP_HYSTERESIS, CFG_W'($urandom_range(0, 40000)));
                if ($urandom_range(0, 1) == 0)
                    write_reg(cmhd_pkg::REG_GAP_HYSTERESIS
                              + cmhd_pkg::cfg_index_t'($urandom_range(1, 3)),
                              CFG_W'($urandom));
            end
        endcase
    endtask

    initial
    begin
        cmhd_pkg::item_t rd;
        int unsigned     sent;
        int unsigned     pick;
        int unsigned     count;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed readings on the reset register values
        send_reading(make_reading(0, 0, 0));
        send_reading(make_reading(PULSE_MAX, PULSE_MAX, PULSE_MAX));
        // all channels map to full scale: zero span
        send_reading(make_reading(RED_LOW, GREEN_LOW, BLUE_LOW));
        // all channels map to zero: zero span
        send_reading(make_reading(RED_HIGH, GREEN_HIGH, BLUE_HIGH));
        // narrow span that gets widened
        send_reading(make_reading(RED_LOW, GREEN_LOW + 1, BLUE_LOW));
        send_reading(make_reading(RED_HIGH, GREEN_LOW, BLUE_LOW));
        send_reading(make_reading(PULSE_MAX, 0, 0));
        send_reading(make_reading(0, PULSE_MAX, 0));
        send_reading(make_reading(0, 0, PULSE_MAX));
        send_reading(make_reading(PULSE_ALT_A, PULSE_ALT_B, PULSE_ALT_A));
        send_reading(make_reading(PULSE_ALT_B, PULSE_ALT_A, PULSE_ALT_B));
        wait_quiet();

        // Reference cyan; upper data bits on colour registers must be dropped
        settings_used++;
        write_reg(cmhd_pkg::REG_REFERENCE_RED, 18'h3FF00);
        write_reg(cmhd_pkg::REG_REFERENCE_GREEN, 18'h200FF);
        write_reg(cmhd_pkg::REG_REFERENCE_BLUE, 18'h000FF);
        write_reg(cmhd_pkg::REG_GAP_CENTER, cmhd_pkg::GAP_CENTER_RESET);
        write_reg(cmhd_pkg::REG_GAP_HYSTERESIS, cmhd_pkg::GAP_HYSTERESIS_RESET);
        write_reg(cmhd_pkg::REG_GAP_HYSTERESIS + cmhd_pkg::cfg_index_t'(1), '1);
        // settle onto the reference: flag sets, then move away: flag clears
        send_repeated(make_reading(RED_HIGH, GREEN_LOW, BLUE_LOW), 4);
        send_repeated(make_reading(RED_LOW, GREEN_HIGH, BLUE_HIGH), 4);
        wait_quiet();

        // Negative lower bound: an exact match must never set the flag
        settings_used++;
        write_reg(cmhd_pkg::REG_GAP_CENTER, '0);
        write_reg(cmhd_pkg::REG_GAP_HYSTERESIS, '1);
        send_repeated(make_reading(RED_HIGH, GREEN_LOW, BLUE_LOW), 3);
        wait_quiet();

        // Random phases, each on its own register setting
        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            program_phase(phase);
            tx_idling = (phase != RANDOM_PHASES - 1);
            rx_idling = (phase != RANDOM_PHASES - 1) && (phase != 5);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 9);
                if (pick <= 5)
                    rd = make_reading($urandom_range(20, 100), $urandom_range(20, 100),
                                      $urandom_range(20, 100));
                else if (pick <= 7)
                    rd = make_reading($urandom, $urandom, $urandom);
                else
                    rd = make_reading(RED_LOW + $urandom_range(0, 3),
                                      GREEN_LOW + $urandom_range(0, 4),
                                      BLUE_LOW + $urandom_range(0, 3));
                // steady colours let the average settle and the flag move
                count = (pick <= 3) ? $urandom_range(2, 8) : 1;
                if (phase == 3 && sent < PHASE_ITEMS / 3 && sent + count >= PHASE_ITEMS / 3)
                    long_hold_req = 1'b1;
                send_repeated(rd, count);
                sent += count;
            end
            wait_quiet();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d readings, %0d results, %0d register settings, %0d writes",
                 tracker.readings, tracker.results_seen, settings_used, tracker.reg_writes);
        $display("detect flag changed %0d times, %0d long output holds, %0d mismatches",
                 tracker.flag_changes, long_holds, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
